/* design/lwenc_pkg.sv */
// lwenc_pkg: shared types, constants and aes helper functions
// used by the front, the aes core and the back of the uplink encryptor
package lwenc_pkg;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEV_ADDRESS = 3'd0,
      CSR_APP_KEY_HI  = 3'd1,
      CSR_APP_KEY_LO  = 3'd2,
      CSR_NET_KEY_HI  = 3'd3,
      CSR_NET_KEY_LO  = 3'd4
   } csr_index_type;

   localparam logic [7:0] MHDR_UP     = 8'h40;
   localparam logic [7:0] FCTRL_UP    = 8'h80;
   localparam logic [7:0] FPORT_UP    = 8'h01;
   localparam logic [7:0] B0_TAG      = 8'h49;
   localparam logic [7:0] A_TAG       = 8'h01;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [7:0] HDR_BYTES   = 8'd9;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [7:0] payload_length;
   } item_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xt(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // byte 0 sits in the top bits
   function automatic logic [7:0] byte_at(input logic [127:0] b, input logic [3:0] i);
      return b[7'd127 - {i, 3'b000} -: 8];
   endfunction

   function automatic logic [127:0] byte_mask(input logic [7:0] v, input logic [3:0] i);
      return {v, 120'b0} >> {i, 3'b000};
   endfunction

   function automatic logic [127:0] dbl(input logic [127:0] b);
      return {b[126:0], 1'b0} ^ (b[127] ? 128'h87 : 128'h0);
   endfunction

   function automatic logic [127:0] next_rk(input logic [127:0] rk, input logic [7:0] rcon);
      logic [31:0] tmp;
      logic [31:0] w0, w1, w2, w3;
      tmp = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
      w0  = rk[127:96] ^ tmp;
      w1  = rk[95:64] ^ w0;
      w2  = rk[63:32] ^ w1;
      w3  = rk[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last_rnd);
      logic [7:0]   sb [16];
      logic [7:0]   t  [16];
      logic [127:0] r;
      logic [7:0]   a0, a1, a2, a3, al;
      for (int i = 0; i < 16; i++) sb[i] = SBOX[byte_at(s, 4'(i))];
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++) t[i + 4*c] = sb[i + 4*((c + i) % 4)];
      r = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
         al = a0 ^ a1 ^ a2 ^ a3;
         if (!last_rnd) begin
            a0 = t[4*c] ^ al ^ xt(t[4*c] ^ t[4*c+1]);
            a1 = t[4*c+1] ^ al ^ xt(t[4*c+1] ^ t[4*c+2]);
            a2 = t[4*c+2] ^ al ^ xt(t[4*c+2] ^ t[4*c+3]);
            a3 = t[4*c+3] ^ al ^ xt(t[4*c+3] ^ t[4*c]);
         end
         r[127 - 32*c -: 32] = {a0, a1, a2, a3};
      end
      return r;
   endfunction

endpackage

/* design/lwenc_front.sv */
// lwenc_front: input stage, a two-word queue of payload words
// depends on lwenc_pkg
module lwenc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  lwenc_pkg::item_type req_item,
   output logic                q_valid,
   output lwenc_pkg::item_type q_item,
   input  logic                q_pop
);
   import lwenc_pkg::*;

   item_type   mem_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ (q_pop && q_valid);
      cnt_in  = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= req_item;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |=> (cnt_ff <= 2'd1)) else $error("pop from empty queue");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !q_pop) |=> (cnt_ff == 2'd2)) else $error("push into full queue");
endmodule

/* design/lwenc_aes.sv */
// lwenc_aes: iterative aes-128 encryptor, one round per cycle
// depends on lwenc_pkg
module lwenc_aes (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] key,
   input  logic [127:0] din,
   output logic         done,
   output logic [127:0] dout
);
   import lwenc_pkg::*;

   logic [127:0] s_ff, s_in, rk_ff, rk_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [127:0] rk_nx;

   assign rk_nx = next_rk(rk_ff, rcon_ff);
   assign done  = done_ff;
   assign dout  = s_ff;

   always_comb begin
      s_in    = s_ff;
      rk_in   = rk_ff;
      rcon_in = rcon_ff;
      rnd_in  = rnd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         s_in    = din ^ key;
         rk_in   = key;
         rcon_in = 8'h01;
         rnd_in  = 4'd1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         s_in    = aes_round(s_ff, rnd_ff == 4'd10) ^ rk_nx;
         rk_in   = rk_nx;
         rcon_in = xt(rcon_ff);
         rnd_in  = rnd_ff + 4'd1;
         if (rnd_ff == 4'd10) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rnd_ff  <= rnd_in;
      end
      s_ff    <= s_in;
      rk_ff   <= rk_in;
      rcon_ff <= rcon_in;
   end

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without a block in flight");
   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rnd_ff >= 4'd1 && rnd_ff <= 4'd10)) else $error("round out of range");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
endmodule

/* design/lwenc_back.sv */
// lwenc_back: frame sequencer, header, ctr encryption, cmac chain and mic output
// depends on lwenc_pkg and lwenc_aes
module lwenc_back #(
   parameter int unsigned MAX_PAYLOAD = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  lwenc_pkg::item_type q_item,
   output logic                q_pop,
   input  logic [31:0]         dev_address,
   input  logic [127:0]        app_key,
   input  logic [127:0]        net_key,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);
   import lwenc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SUB, S_B0, S_HDR, S_PAY, S_KS, S_PEMIT, S_CW, S_POST, S_MIC, S_MEMIT
   } state_type;

   state_type    state_ff;
   logic [31:0]  fc_ff;
   logic [127:0] chain_ff, ks_ff, sub_ff;
   logic [7:0]   pos_ff, len_ff, pb_ff, total;
   logic [3:0]   idx_ff;
   logic         ovalid_ff, olast_ff, ovalid_in;
   logic [7:0]   odata_ff;
   logic         astart_ff, astart_in;
   logic         emit_word;
   logic [127:0] akey_ff, adin_ff;
   logic         aes_done;
   logic [127:0] aes_out;
   logic         slot_free;
   logic [7:0]   len_clamp, hdr_byte, cbyte, m;
   logic [127:0] b0_blk, a_blk, fin_blk, chain_upd;

   lwenc_aes u_aes (
      .clock(clock), .reset(reset), .start(astart_ff), .key(akey_ff), .din(adin_ff),
      .done(aes_done), .dout(aes_out)
   );

   assign slot_free  = !ovalid_ff || rsp_tready;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign total      = HDR_BYTES + len_ff;
   assign m          = HDR_BYTES + pos_ff;
   assign cbyte      = pb_ff ^ byte_at(ks_ff, pos_ff[3:0]);
   assign chain_upd  = chain_ff ^ byte_mask(cbyte, m[3:0]);

   always_comb begin
      if (q_item.payload_length == 8'd0) len_clamp = 8'd1;
      else if (q_item.payload_length > 8'(MAX_PAYLOAD)) len_clamp = 8'(MAX_PAYLOAD);
      else len_clamp = q_item.payload_length;
   end

   always_comb begin
      b0_blk = {B0_TAG, 40'h0, dev_address[7:0], dev_address[15:8], dev_address[23:16],
                dev_address[31:24], fc_ff[7:0], fc_ff[15:8], fc_ff[23:16], fc_ff[31:24],
                8'h00, total};
      a_blk  = {A_TAG, 40'h0, dev_address[7:0], dev_address[15:8], dev_address[23:16],
                dev_address[31:24], fc_ff[7:0], fc_ff[15:8], fc_ff[23:16], fc_ff[31:24],
                8'h00, 8'({4'h0, pos_ff[7:4]} + 8'd1)};
      fin_blk = chain_ff ^ sub_ff ^
                ((total[3:0] != 4'd0) ? byte_mask(PAD_BYTE, total[3:0]) : 128'h0);
   end

   always_comb begin
      case (idx_ff)
         4'd0:    hdr_byte = MHDR_UP;
         4'd1:    hdr_byte = dev_address[7:0];
         4'd2:    hdr_byte = dev_address[15:8];
         4'd3:    hdr_byte = dev_address[23:16];
         4'd4:    hdr_byte = dev_address[31:24];
         4'd5:    hdr_byte = FCTRL_UP;
         4'd6:    hdr_byte = fc_ff[7:0];
         4'd7:    hdr_byte = fc_ff[15:8];
         default: hdr_byte = FPORT_UP;
      endcase
   end

   // aes start pulse and output word load
   always_comb begin
      astart_in = 1'b0;
      emit_word = 1'b0;
      case (state_ff)
         S_IDLE:  astart_in = q_valid && (pos_ff == 8'd0);
         S_SUB:   astart_in = aes_done;
         S_HDR:   emit_word = slot_free;
         S_PAY:   astart_in = (pos_ff[3:0] == 4'd0);
         S_PEMIT: begin
            emit_word = slot_free;
            astart_in = slot_free && (m[3:0] == 4'hf) && ((pos_ff + 8'd1) != len_ff);
         end
         S_POST:  astart_in = ((pos_ff + 8'd1) >= len_ff);
         S_MEMIT: emit_word = slot_free;
         default: ;
      endcase
      ovalid_in = emit_word ? 1'b1 : (rsp_tready ? 1'b0 : ovalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fc_ff     <= '0;
         pos_ff    <= '0;
         len_ff    <= '0;
         idx_ff    <= '0;
         ovalid_ff <= 1'b0;
         astart_ff <= 1'b0;
         chain_ff  <= '0;
      end else begin
         astart_ff <= astart_in;
         ovalid_ff <= ovalid_in;
         case (state_ff)
            S_IDLE: if (q_valid) begin
               pb_ff <= q_item.payload_byte;
               if (pos_ff == 8'd0) begin
                  len_ff    <= len_clamp;
                  akey_ff   <= net_key;
                  adin_ff   <= '0;
                  state_ff  <= S_SUB;
               end else begin
                  state_ff <= S_PAY;
               end
            end
            S_SUB: if (aes_done) begin
               sub_ff    <= (total[3:0] != 4'd0) ? dbl(dbl(aes_out)) : dbl(aes_out);
               akey_ff   <= net_key;
               adin_ff   <= b0_blk;
               state_ff  <= S_B0;
            end
            S_B0: if (aes_done) begin
               chain_ff <= aes_out;
               idx_ff   <= 4'd0;
               state_ff <= S_HDR;
            end
            S_HDR: if (slot_free) begin
               odata_ff  <= hdr_byte;
               olast_ff  <= 1'b0;
               chain_ff  <= chain_ff ^ byte_mask(hdr_byte, idx_ff);
               idx_ff    <= idx_ff + 4'd1;
               if (idx_ff == 4'd8) state_ff <= S_PAY;
            end
            S_PAY: if (pos_ff[3:0] == 4'd0) begin
               akey_ff   <= app_key;
               adin_ff   <= a_blk;
               state_ff  <= S_KS;
            end else begin
               state_ff <= S_PEMIT;
            end
            S_KS: if (aes_done) begin
               ks_ff    <= aes_out;
               state_ff <= S_PEMIT;
            end
            S_PEMIT: if (slot_free) begin
               odata_ff  <= cbyte;
               olast_ff  <= 1'b0;
               chain_ff  <= chain_upd;
               if (m[3:0] == 4'hf && (pos_ff + 8'd1) != len_ff) begin
                  akey_ff   <= net_key;
                  adin_ff   <= chain_upd;
                  state_ff  <= S_CW;
               end else begin
                  state_ff <= S_POST;
               end
            end
            S_CW: if (aes_done) begin
               chain_ff <= aes_out;
               state_ff <= S_POST;
            end
            S_POST: if ((pos_ff + 8'd1) >= len_ff) begin
               akey_ff   <= net_key;
               adin_ff   <= fin_blk;
               state_ff  <= S_MIC;
            end else begin
               pos_ff   <= pos_ff + 8'd1;
               state_ff <= S_IDLE;
            end
            S_MIC: if (aes_done) begin
               chain_ff <= aes_out;
               idx_ff   <= 4'd0;
               state_ff <= S_MEMIT;
            end
            S_MEMIT: if (slot_free) begin
               odata_ff  <= byte_at(chain_ff, idx_ff);
               olast_ff  <= (idx_ff == 4'd3);
               idx_ff    <= idx_ff + 4'd1;
               if (idx_ff == 4'd3) begin
                  fc_ff    <= fc_ff + 32'd1;
                  pos_ff   <= 8'd0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != 8'd0) |-> (pos_ff < len_ff)) else $error("payload position past length");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !rsp_tready) |=> ($stable(odata_ff) && ovalid_ff))
      else $error("held word overwritten");
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      aes_done |-> (state_ff == S_SUB || state_ff == S_B0 || state_ff == S_KS ||
                    state_ff == S_CW || state_ff == S_MIC)) else $error("stray aes result");
endmodule

/* design/lorawan_uplink_encrypt_mic.sv */
// lorawan_uplink_encrypt_mic: top level, config registers, front queue and back sequencer
// depends on lwenc_pkg, lwenc_front, lwenc_back, lwenc_aes
//
// usage
//   req_* takes plaintext payload words; payload_length is read with the
//   first word of a frame (0 counts as 1, above MAX_PAYLOAD saturates)
//   rsp_* gives the frame: 9 header bytes, ciphertext, 4 mic bytes, tlast on
//   the final mic byte
//   csr_* writes dev_address, app key and net key halves, idle only
// steps per payload word
//   a mid-frame word steps through the idle, payload, emit and post states; a word
//   that opens a keystream block or closes a 16-byte cmac block also runs one
//   block through the shared aes core
//   the first word of a frame runs two more aes blocks and 9 header words
//   the last word adds one aes block and 4 mic words
// reset clears the frame counter, queue and output register
// when rsp_tready is low the output word holds, the sequencer waits and the
// two-word input queue fills before req_tready drops
module lorawan_uplink_encrypt_mic #(
   parameter int unsigned MAX_PAYLOAD = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // payload_byte, payload_length
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // frame_byte
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [lwenc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lwenc_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import lwenc_pkg::*;

   logic [31:0]  dev_ff;
   logic [127:0] app_ff, net_ff;
   item_type     req_item, q_item;
   logic         q_valid, q_pop;

   assign req_item.payload_byte   = req_tdata[7:0];
   assign req_item.payload_length = req_tdata[15:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff <= '0;
         app_ff <= '0;
         net_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEV_ADDRESS: dev_ff         <= csr_wdata[31:0];
            CSR_APP_KEY_HI:  app_ff[127:64] <= csr_wdata;
            CSR_APP_KEY_LO:  app_ff[63:0]   <= csr_wdata;
            CSR_NET_KEY_HI:  net_ff[127:64] <= csr_wdata;
            CSR_NET_KEY_LO:  net_ff[63:0]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   lwenc_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_item(req_item), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   lwenc_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .dev_address(dev_ff), .app_key(app_ff), .net_key(net_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );
endmodule
